/* sv/tpr_pkg.sv */
// tpr_pkg: types, field widths and codes of the touch report poller
// no dependencies; used by every other file of the block

package tpr_pkg;

  localparam int TIME_W   = 32;
  localparam int RAW_W    = 16;
  localparam int PT_W     = 12;
  localparam int STAT_W   = 8;
  localparam int IVL_W    = 16;
  localparam int CNT_W    = 4;
  localparam int OC_W     = 3;
  localparam int CIDX_W   = 3;
  localparam int CDATA_W  = 16;

  localparam int READY_BIT = 7;
  localparam logic [STAT_W-1:0] COUNT_MASK = 8'h0F;

  // outcome codes
  localparam logic [OC_W-1:0] OUT_TOO_EARLY  = 3'd0;
  localparam logic [OC_W-1:0] OUT_READ_FAIL  = 3'd1;
  localparam logic [OC_W-1:0] OUT_NOT_READY  = 3'd2;
  localparam logic [OC_W-1:0] OUT_BAD_COUNT  = 3'd3;
  localparam logic [OC_W-1:0] OUT_OFF_SCREEN = 3'd4;
  localparam logic [OC_W-1:0] OUT_NEW_POINT  = 3'd5;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_SWAP_AXES  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_INVERT_X   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_INVERT_Y   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_ACTIVE_MS  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_IDLE_MS    = 3'd4;
  localparam logic [CIDX_W-1:0] REG_DISP_W     = 3'd5;
  localparam logic [CIDX_W-1:0] REG_DISP_H     = 3'd6;
  localparam logic [CIDX_W-1:0] REG_MAX_POINTS = 3'd7;

  // register reset values
  localparam logic [IVL_W-1:0] RST_ACTIVE_MS  = 16'd8;
  localparam logic [IVL_W-1:0] RST_IDLE_MS    = 16'd32;
  localparam logic [PT_W-1:0]  RST_DISP_W     = 12'd800;
  localparam logic [PT_W-1:0]  RST_DISP_H     = 12'd480;
  localparam logic [CNT_W-1:0] RST_MAX_POINTS = 4'd5;

  typedef struct packed {
    logic              swap_axes;
    logic              invert_x;
    logic              invert_y;
    logic [IVL_W-1:0]  active_poll_ms;
    logic [IVL_W-1:0]  idle_poll_ms;
    logic [PT_W-1:0]   display_width;
    logic [PT_W-1:0]   display_height;
    logic [CNT_W-1:0]  max_points;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              read_ok;
    logic [STAT_W-1:0] status_byte;
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
  } item_t;

  typedef struct packed {
    logic            touched;
    logic [PT_W-1:0] point_x;
    logic [PT_W-1:0] point_y;
    logic            polled;
    logic            clear_request;
    logic [OC_W-1:0] outcome;
  } result_t;

endpackage

/* sv/tpr_if.sv */
// tpr_in_if / tpr_out_if: valid-ready channels of the touch report poller
// depends on tpr_pkg for field widths

interface tpr_in_if;
  logic                        valid;
  logic                        ready;
  logic [tpr_pkg::TIME_W-1:0]  now_ms;
  logic                        read_ok;
  logic [tpr_pkg::STAT_W-1:0]  status_byte;
  logic [tpr_pkg::RAW_W-1:0]   raw_x;
  logic [tpr_pkg::RAW_W-1:0]   raw_y;

  modport source (output valid, now_ms, read_ok, status_byte, raw_x, raw_y, input ready);
  modport sink   (input valid, now_ms, read_ok, status_byte, raw_x, raw_y, output ready);
endinterface

interface tpr_out_if;
  logic                       valid;
  logic                       ready;
  logic                       touched;
  logic [tpr_pkg::PT_W-1:0]   point_x;
  logic [tpr_pkg::PT_W-1:0]   point_y;
  logic                       polled;
  logic                       clear_request;
  logic [tpr_pkg::OC_W-1:0]   outcome;

  modport source (output valid, touched, point_x, point_y, polled, clear_request, outcome,
                  input ready);
  modport sink   (input valid, touched, point_x, point_y, polled, clear_request, outcome,
                  output ready);
endinterface

/* sv/tpr_cfg.sv */
// tpr_cfg: configuration register file of the touch report poller
// depends on tpr_pkg for cfg_t, register indexes and reset values

module tpr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tpr_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [tpr_pkg::CDATA_W-1:0]   cfg_wdata,
  output tpr_pkg::cfg_t                 cfg
);

  tpr_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        tpr_pkg::REG_SWAP_AXES:  cfg_nxt.swap_axes      = cfg_wdata[0];
        tpr_pkg::REG_INVERT_X:   cfg_nxt.invert_x       = cfg_wdata[0];
        tpr_pkg::REG_INVERT_Y:   cfg_nxt.invert_y       = cfg_wdata[0];
        tpr_pkg::REG_ACTIVE_MS:  cfg_nxt.active_poll_ms = cfg_wdata[tpr_pkg::IVL_W-1:0];
        tpr_pkg::REG_IDLE_MS:    cfg_nxt.idle_poll_ms   = cfg_wdata[tpr_pkg::IVL_W-1:0];
        tpr_pkg::REG_DISP_W:     cfg_nxt.display_width  = cfg_wdata[tpr_pkg::PT_W-1:0];
        tpr_pkg::REG_DISP_H:     cfg_nxt.display_height = cfg_wdata[tpr_pkg::PT_W-1:0];
        tpr_pkg::REG_MAX_POINTS: cfg_nxt.max_points     = cfg_wdata[tpr_pkg::CNT_W-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swap_axes      <= 1'b0;
      cfg_r.invert_x       <= 1'b0;
      cfg_r.invert_y       <= 1'b0;
      cfg_r.active_poll_ms <= tpr_pkg::RST_ACTIVE_MS;
      cfg_r.idle_poll_ms   <= tpr_pkg::RST_IDLE_MS;
      cfg_r.display_width  <= tpr_pkg::RST_DISP_W;
      cfg_r.display_height <= tpr_pkg::RST_DISP_H;
      cfg_r.max_points     <= tpr_pkg::RST_MAX_POINTS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/tpr_eval.sv */
// tpr_eval: combinational evaluation of one poll request against the poller state
// depends on tpr_pkg for cfg_t, item_t, result_t and outcome codes

module tpr_eval #(
  parameter int COORD_WIDTH = 12
) (
  input  tpr_pkg::cfg_t                 cfg,
  input  tpr_pkg::item_t                item,
  input  logic [tpr_pkg::TIME_W-1:0]    last_poll,
  input  logic                          touch_active,
  input  logic [COORD_WIDTH-1:0]        cached_x,
  input  logic [COORD_WIDTH-1:0]        cached_y,
  output tpr_pkg::result_t              res,
  output logic [tpr_pkg::TIME_W-1:0]    last_poll_nxt,
  output logic                          touch_active_nxt,
  output logic [COORD_WIDTH-1:0]        cached_x_nxt,
  output logic [COORD_WIDTH-1:0]        cached_y_nxt
);

  localparam int EXT_W = tpr_pkg::RAW_W - tpr_pkg::PT_W;

  logic [tpr_pkg::IVL_W-1:0]  interval;
  logic [tpr_pkg::TIME_W-1:0] elapsed;
  logic                       early;
  logic [tpr_pkg::CNT_W-1:0]  count;
  logic [tpr_pkg::RAW_W-1:0]  sx, sy;
  logic                       on_x, on_y;
  logic [tpr_pkg::PT_W-1:0]   fx, fy;
  logic [COORD_WIDTH-1:0]     kx, ky;

  assign interval = touch_active ? cfg.active_poll_ms : cfg.idle_poll_ms;
  assign elapsed  = item.now_ms - last_poll;
  assign early    = elapsed < {{(tpr_pkg::TIME_W-tpr_pkg::IVL_W){1'b0}}, interval};
  assign count    = tpr_pkg::CNT_W'(item.status_byte & tpr_pkg::COUNT_MASK);

  assign sx = cfg.swap_axes ? item.raw_y : item.raw_x;
  assign sy = cfg.swap_axes ? item.raw_x : item.raw_y;

  // mirrored or not, a coordinate is on screen exactly when the unmirrored one is below the size
  assign on_x = sx < {{EXT_W{1'b0}}, cfg.display_width};
  assign on_y = sy < {{EXT_W{1'b0}}, cfg.display_height};

  assign fx = cfg.invert_x ? (cfg.display_width - tpr_pkg::PT_W'(1) - sx[tpr_pkg::PT_W-1:0])
                           : sx[tpr_pkg::PT_W-1:0];
  assign fy = cfg.invert_y ? (cfg.display_height - tpr_pkg::PT_W'(1) - sy[tpr_pkg::PT_W-1:0])
                           : sy[tpr_pkg::PT_W-1:0];

  assign kx = COORD_WIDTH'(fx);
  assign ky = COORD_WIDTH'(fy);

  always_comb begin
    res              = '0;
    last_poll_nxt    = last_poll;
    touch_active_nxt = touch_active;
    cached_x_nxt     = cached_x;
    cached_y_nxt     = cached_y;
    if (early) begin
      res.outcome = tpr_pkg::OUT_TOO_EARLY;
      if (touch_active) begin
        res.touched = 1'b1;
        res.point_x = tpr_pkg::PT_W'(cached_x);
        res.point_y = tpr_pkg::PT_W'(cached_y);
      end
    end else begin
      last_poll_nxt    = item.now_ms;
      touch_active_nxt = 1'b0;
      res.polled       = 1'b1;
      if (!item.read_ok) begin
        res.outcome = tpr_pkg::OUT_READ_FAIL;
      end else if (!item.status_byte[tpr_pkg::READY_BIT]) begin
        res.outcome = tpr_pkg::OUT_NOT_READY;
      end else begin
        res.clear_request = 1'b1;
        if (count == '0 || count > cfg.max_points) begin
          res.outcome = tpr_pkg::OUT_BAD_COUNT;
        end else if (!on_x || !on_y) begin
          res.outcome = tpr_pkg::OUT_OFF_SCREEN;
        end else begin
          res.outcome      = tpr_pkg::OUT_NEW_POINT;
          res.touched      = 1'b1;
          res.point_x      = tpr_pkg::PT_W'(kx);
          res.point_y      = tpr_pkg::PT_W'(ky);
          touch_active_nxt = 1'b1;
          cached_x_nxt     = kx;
          cached_y_nxt     = ky;
        end
      end
    end
  end

endmodule

/* sv/touch_report_poller_unit.sv */
// touch_report_poller_unit: top level of the single-point touch report poller
// depends on tpr_pkg, tpr_if (channels), tpr_cfg and tpr_eval

// channel  dir  handshake        payload
// in_ch    in   valid / ready    now_ms, read_ok, status_byte, raw_x, raw_y
// out_ch   out  valid / ready    touched, point_x, point_y, polled, clear_request, outcome
// cfg_*    in   cfg_we only      cfg_index (3 b), cfg_wdata (16 b)
//
// one beat in, one beat out; a request taken goes to the input register and then to the
// result register once it is free; while out_ch.ready is high the rate is one per cycle
// the poll state is updated when a request moves from the input register to the
// result register, so the next request in the input register sees it at once
// sync active-low reset clears valids, poll state and config to defaults
// out_ch.ready low holds the result; the input register keeps filling until both are full

module touch_report_poller_unit #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tpr_in_if.sink                        in_ch,
  tpr_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [tpr_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [tpr_pkg::CDATA_W-1:0]   cfg_wdata
);

  tpr_pkg::cfg_t    cfg;

  // input register
  logic             s1_v_r, s1_v_nxt;
  tpr_pkg::item_t   s1_item_r;

  // result register
  logic             out_v_r, out_v_nxt;
  tpr_pkg::result_t out_res_r;
  tpr_pkg::result_t res_nxt;

  // poll state
  logic [tpr_pkg::TIME_W-1:0] last_poll_r, last_poll_nxt;
  logic                       touch_active_r, touch_active_nxt;
  logic [COORD_WIDTH-1:0]     cached_x_r, cached_x_nxt;
  logic [COORD_WIDTH-1:0]     cached_y_r, cached_y_nxt;

  logic in_acc;
  logic adv;

  tpr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tpr_eval #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_eval (
    .cfg              (cfg),
    .item             (s1_item_r),
    .last_poll        (last_poll_r),
    .touch_active     (touch_active_r),
    .cached_x         (cached_x_r),
    .cached_y         (cached_y_r),
    .res              (res_nxt),
    .last_poll_nxt    (last_poll_nxt),
    .touch_active_nxt (touch_active_nxt),
    .cached_x_nxt     (cached_x_nxt),
    .cached_y_nxt     (cached_y_nxt)
  );

  // item moves on when the result register is empty or being drained
  assign adv         = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
      last_poll_r    <= '0;
      touch_active_r <= 1'b0;
      cached_x_r     <= '0;
      cached_y_r     <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (adv) begin
        last_poll_r    <= last_poll_nxt;
        touch_active_r <= touch_active_nxt;
        cached_x_r     <= cached_x_nxt;
        cached_y_r     <= cached_y_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.now_ms      <= in_ch.now_ms;
      s1_item_r.read_ok     <= in_ch.read_ok;
      s1_item_r.status_byte <= in_ch.status_byte;
      s1_item_r.raw_x       <= in_ch.raw_x;
      s1_item_r.raw_y       <= in_ch.raw_y;
    end
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.touched       = out_res_r.touched;
  assign out_ch.point_x       = out_res_r.point_x;
  assign out_ch.point_y       = out_res_r.point_y;
  assign out_ch.polled        = out_res_r.polled;
  assign out_ch.clear_request = out_res_r.clear_request;
  assign out_ch.outcome       = out_res_r.outcome;

`ifndef SYNTHESIS
  // a stalled input beat must stay in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv |=> s1_v_r)
    else $error("input register lost a stalled beat");

  // a new point must make the touch active
  a_touch_rise: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_nxt.outcome == tpr_pkg::OUT_NEW_POINT |=> touch_active_r)
    else $error("new point did not set touch active");

  // a status clear is only asked for on a consumed report
  a_clr_polled: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.clear_request |-> out_res_r.polled)
    else $error("clear request without poll");

  // a reported point comes only from a new point or a cached touch
  a_touched_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.touched |->
      (out_res_r.outcome == tpr_pkg::OUT_NEW_POINT ||
       out_res_r.outcome == tpr_pkg::OUT_TOO_EARLY))
    else $error("touched with a rejecting outcome");
`endif

endmodule

/* tb/sv/tpr_poll_checker.sv */
`timescale 1ns / 1ps
// tpr_poll_checker: watches the poll and report channels, predicts each report beat
// depends on tpr_pkg and the tpr_in_if / tpr_out_if channels

module tpr_poll_checker
  import tpr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  tpr_in_if                   in_ch,
  tpr_out_if                  out_ch,
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CDATA_W-1:0]  cfg_wdata,
  output int                  fail_count,
  output int                  expected_left
);

  cfg_t              shadow;
  logic [TIME_W-1:0] last_poll_ms;
  logic              touch_held;
  logic [PT_W-1:0]   held_x;
  logic [PT_W-1:0]   held_y;
  result_t           expected_reports[$];
  int                mismatches = 0;
  int                report_beats = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t ns, report beat %0d: %s", $time, report_beats, msg);
    mismatches++;
  endtask

  // advances the poller state by one request and returns its report
  function automatic result_t next_report(item_t it);
    result_t           r;
    logic [TIME_W-1:0] elapsed;
    logic [IVL_W-1:0]  ivl;
    logic [CNT_W-1:0]  cnt;
    int                px;
    int                py;
    int                swap_tmp;
    r = '0;
    ivl = touch_held ? shadow.active_poll_ms : shadow.idle_poll_ms;
    elapsed = it.now_ms - last_poll_ms;
    cnt = CNT_W'(it.status_byte & COUNT_MASK);
    if (elapsed < TIME_W'(ivl)) begin
      r.outcome = OUT_TOO_EARLY;
      if (touch_held) begin
        r.touched = 1'b1;
        r.point_x = held_x;
        r.point_y = held_y;
      end
    end else begin
      last_poll_ms = it.now_ms;
      r.polled = 1'b1;
      touch_held = 1'b0;
      px = int'(it.raw_x);
      py = int'(it.raw_y);
      if (shadow.swap_axes) begin
        swap_tmp = px;
        px = py;
        py = swap_tmp;
      end
      if (shadow.invert_x) px = int'(shadow.display_width) - 1 - px;
      if (shadow.invert_y) py = int'(shadow.display_height) - 1 - py;
      if (!it.read_ok) begin
        r.outcome = OUT_READ_FAIL;
      end else if (!it.status_byte[READY_BIT]) begin
        r.outcome = OUT_NOT_READY;
      end else begin
        r.clear_request = 1'b1;
        if (cnt == '0 || cnt > shadow.max_points) begin
          r.outcome = OUT_BAD_COUNT;
        end else if (px < 0 || py < 0 || px >= int'(shadow.display_width) ||
                     py >= int'(shadow.display_height)) begin
          r.outcome = OUT_OFF_SCREEN;
        end else begin
          touch_held = 1'b1;
          held_x = px[PT_W-1:0];
          held_y = py[PT_W-1:0];
          r.touched = 1'b1;
          r.point_x = held_x;
          r.point_y = held_y;
          r.outcome = OUT_NEW_POINT;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    item_t   req;
    result_t got;
    result_t want;
    if (!rst_n) begin
      shadow.swap_axes      = 1'b0;
      shadow.invert_x       = 1'b0;
      shadow.invert_y       = 1'b0;
      shadow.active_poll_ms = RST_ACTIVE_MS;
      shadow.idle_poll_ms   = RST_IDLE_MS;
      shadow.display_width  = RST_DISP_W;
      shadow.display_height = RST_DISP_H;
      shadow.max_points     = RST_MAX_POINTS;
      last_poll_ms = '0;
      touch_held   = 1'b0;
      held_x       = '0;
      held_y       = '0;
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SWAP_AXES:  shadow.swap_axes      = cfg_wdata[0];
          REG_INVERT_X:   shadow.invert_x       = cfg_wdata[0];
          REG_INVERT_Y:   shadow.invert_y       = cfg_wdata[0];
          REG_ACTIVE_MS:  shadow.active_poll_ms = cfg_wdata[IVL_W-1:0];
          REG_IDLE_MS:    shadow.idle_poll_ms   = cfg_wdata[IVL_W-1:0];
          REG_DISP_W:     shadow.display_width  = cfg_wdata[PT_W-1:0];
          REG_DISP_H:     shadow.display_height = cfg_wdata[PT_W-1:0];
          REG_MAX_POINTS: shadow.max_points     = cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      // take the report beat first so a request taken on the same edge cannot match it
      if (out_ch.valid && out_ch.ready) begin
        got.touched       = out_ch.touched;
        got.point_x       = out_ch.point_x;
        got.point_y       = out_ch.point_y;
        got.polled        = out_ch.polled;
        got.clear_request = out_ch.clear_request;
        got.outcome       = out_ch.outcome;
        if (expected_reports.size() == 0) begin
          report_mismatch($sformatf("report with nothing expected: %p", got));
        end else begin
          want = expected_reports.pop_front();
          if (got.touched !== want.touched || got.point_x !== want.point_x ||
              got.point_y !== want.point_y || got.polled !== want.polled ||
              got.clear_request !== want.clear_request || got.outcome !== want.outcome)
            report_mismatch($sformatf("got %p expected %p", got, want));
        end
        report_beats++;
      end
      if (in_ch.valid && in_ch.ready) begin
        req.now_ms      = in_ch.now_ms;
        req.read_ok     = in_ch.read_ok;
        req.status_byte = in_ch.status_byte;
        req.raw_x       = in_ch.raw_x;
        req.raw_y       = in_ch.raw_y;
        expected_reports.push_back(next_report(req));
      end
    end
    expected_left <= expected_reports.size();
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for touch_report_poller_unit
// depends on tpr_pkg, tpr_in_if / tpr_out_if and tpr_poll_checker

module tb_top;
  import tpr_pkg::*;

  localparam int POLLS_PER_PHASE = 50;
  localparam int N_PHASES        = 9;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CIDX_W-1:0]  cfg_index;
  logic [CDATA_W-1:0] cfg_wdata;
  int                 fail_count;
  int                 expected_left;

  // settings the stimulus is shaped for, and the millisecond clock it walks along
  cfg_t               cur_cfg;
  logic [TIME_W-1:0]  t_now = '0;
  // no idling on either side in the last phase
  bit                 quiet_tail = 1'b0;

  tpr_in_if  in_ch ();
  tpr_out_if out_ch ();

  touch_report_poller_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tpr_poll_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  always #5 clk = ~clk;

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // report side: random stall bursts, none in the quiet tail
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet_tail && rst_n && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  function automatic item_t poll_item(logic [TIME_W-1:0] t, logic ok, logic [STAT_W-1:0] st,
                                      logic [RAW_W-1:0] x, logic [RAW_W-1:0] y);
    item_t it;
    it.now_ms      = t;
    it.read_ok     = ok;
    it.status_byte = st;
    it.raw_x       = x;
    it.raw_y       = y;
    return it;
  endfunction

  // random poll: time steps cluster around the intervals so both early and due
  // polls show up, most reports are well formed and most points lie on the display
  function automatic item_t random_poll();
    item_t             it;
    logic [TIME_W-1:0] ivl;
    logic [TIME_W-1:0] step;
    int                pick;
    int                x_span;
    int                y_span;
    int                top_cnt;
    ivl = TIME_W'($urandom_range(0, 1) ? cur_cfg.active_poll_ms : cur_cfg.idle_poll_ms);
    pick = $urandom_range(0, 99);
    if (pick < 30)      step = $urandom_range(0, ivl);
    else if (pick < 55) step = ivl + $urandom_range(0, 2) - 1;
    else if (pick < 85) step = ivl + $urandom_range(0, 200);
    else if (pick < 95) step = $urandom;
    else                step = '0;
    t_now += step;
    it.now_ms = t_now;
    it.read_ok = ($urandom_range(0, 9) != 0);
    top_cnt = (cur_cfg.max_points == '0) ? 1 : int'(cur_cfg.max_points);
    if ($urandom_range(0, 9) < 7)
      it.status_byte = {1'b1, 3'($urandom), 4'($urandom_range(1, top_cnt))};
    else
      it.status_byte = STAT_W'($urandom);
    // the raw axis that lands on x after a swap is bounded by the width
    x_span = cur_cfg.swap_axes ? int'(cur_cfg.display_height) : int'(cur_cfg.display_width);
    y_span = cur_cfg.swap_axes ? int'(cur_cfg.display_width) : int'(cur_cfg.display_height);
    pick = $urandom_range(0, 7);
    if (pick < 2 || x_span == 0) it.raw_x = RAW_W'($urandom);
    else if (pick == 2)          it.raw_x = '0;
    else if (pick == 3)          it.raw_x = RAW_W'(x_span - 1);
    else                         it.raw_x = RAW_W'($urandom_range(0, x_span - 1));
    pick = $urandom_range(0, 7);
    if (pick < 2 || y_span == 0) it.raw_y = RAW_W'($urandom);
    else if (pick == 2)          it.raw_y = '0;
    else if (pick == 3)          it.raw_y = RAW_W'(y_span - 1);
    else                         it.raw_y = RAW_W'($urandom_range(0, y_span - 1));
    return it;
  endfunction

  // one poll beat; valid stays up into the next call unless a gap is drawn
  task automatic send_poll(item_t it);
    in_ch.valid       <= 1'b1;
    in_ch.now_ms      <= it.now_ms;
    in_ch.read_ok     <= it.read_ok;
    in_ch.status_byte <= it.status_byte;
    in_ch.raw_x       <= it.raw_x;
    in_ch.raw_y       <= it.raw_y;
    do @(posedge clk); while (!in_ch.ready);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // block is idle once every report is back; the task then also lets the pipeline settle
  task automatic wait_drained();
    do @(posedge clk); while (expected_left != 0);
    repeat (4) @(posedge clk);
  endtask

  // all eight registers, one write per cycle, only while idle
  task automatic load_settings(cfg_t c);
    logic [CDATA_W-1:0] vals [8];
    vals[REG_SWAP_AXES]  = CDATA_W'(c.swap_axes);
    vals[REG_INVERT_X]   = CDATA_W'(c.invert_x);
    vals[REG_INVERT_Y]   = CDATA_W'(c.invert_y);
    vals[REG_ACTIVE_MS]  = CDATA_W'(c.active_poll_ms);
    vals[REG_IDLE_MS]    = CDATA_W'(c.idle_poll_ms);
    vals[REG_DISP_W]     = CDATA_W'(c.display_width);
    vals[REG_DISP_H]     = CDATA_W'(c.display_height);
    vals[REG_MAX_POINTS] = CDATA_W'(c.max_points);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CIDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  initial begin
    cfg_t plan [N_PHASES];
    cfg_t mirror_cfg;

    // swap, mirror x/y, active ms, idle ms, width, height, max points
    plan[0] = '{1'b0, 1'b0, 1'b0, 16'd8,     16'd32,    12'd800,  12'd480,  4'd5};
    plan[1] = '{1'b1, 1'b0, 1'b0, 16'd0,     16'd0,     12'd800,  12'd480,  4'd15};
    plan[2] = '{1'b0, 1'b1, 1'b1, 16'd16,    16'd40,    12'd4095, 12'd4095, 4'd15};
    plan[3] = '{1'b1, 1'b1, 1'b0, 16'd65535, 16'd65535, 12'd1,    12'd1,    4'd1};
    plan[4] = '{1'b0, 1'b0, 1'b1, 16'd3,     16'd5,     12'd0,    12'd300,  4'd3};
    plan[5] = '{1'b1, 1'b1, 1'b1, 16'd2,     16'd7,     12'd640,  12'd0,    4'd0};
    plan[6] = '{1'b0, 1'b1, 1'b0, 16'd1,     16'd1,     12'd320,  12'd240,  4'd7};
    plan[7] = '{1'b1, 1'b0, 1'b1, 16'd10,    16'd20,    12'd1024, 12'd600,  4'd5};
    plan[8] = '{1'b0, 1'b0, 1'b0, 16'd8,     16'd32,    12'd800,  12'd480,  4'd5};
    // all axis tricks on, no interval, small display
    mirror_cfg = '{1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 12'd100, 12'd50, 4'd15};

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.now_ms      <= '0;
    in_ch.read_ok     <= 1'b0;
    in_ch.status_byte <= '0;
    in_ch.raw_x       <= '0;
    in_ch.raw_y       <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed polls against the reset settings (idle 32 ms, active 8 ms, 800x480, 5 points)
    cur_cfg = plan[0];
    send_poll(poll_item(32'd5,   1'b1, 8'h81, 16'd10, 16'd10));       // early, nothing held
    send_poll(poll_item(32'd32,  1'b0, 8'h81, 16'd10, 16'd10));       // fetch failed
    send_poll(poll_item(32'd64,  1'b1, 8'h01, 16'd10, 16'd10));       // ready bit clear
    send_poll(poll_item(32'd96,  1'b1, 8'h80, 16'd10, 16'd10));       // zero points
    send_poll(poll_item(32'd128, 1'b1, 8'h86, 16'd10, 16'd10));       // one point too many
    send_poll(poll_item(32'd160, 1'b1, 8'h8F, 16'd10, 16'd10));       // count field all ones
    send_poll(poll_item(32'd192, 1'b1, 8'h85, 16'd800, 16'd0));       // x just off the edge
    send_poll(poll_item(32'd224, 1'b1, 8'h81, 16'd0, 16'd480));       // y just off the edge
    send_poll(poll_item(32'd256, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF));   // raw extremes
    send_poll(poll_item(32'd288, 1'b1, 8'h81, 16'd799, 16'd479));     // far corner, touch held
    send_poll(poll_item(32'd290, 1'b1, 8'h00, 16'd0, 16'd0));         // early, cached point
    send_poll(poll_item(32'd296, 1'b1, 8'h81, 16'd0, 16'd0));         // active interval met
    send_poll(poll_item(32'hFFFF_FFF0, 1'b1, 8'hC5, 16'd123, 16'd45));
    send_poll(poll_item(32'h0000_0002, 1'b0, 8'h81, 16'd1, 16'd1));   // wrap, still due
    send_poll(poll_item(32'h0000_0003, 1'b1, 8'h81, 16'd1, 16'd1));   // early after release
    in_ch.valid <= 1'b0;
    wait_drained();

    // swapped and mirrored: mirroring past the edge goes negative, then two good points
    load_settings(mirror_cfg);
    send_poll(poll_item(32'd1000, 1'b1, 8'h81, 16'd5, 16'd200));
    send_poll(poll_item(32'd1000, 1'b1, 8'h81, 16'd10, 16'd20));      // zero interval, same ms
    send_poll(poll_item(32'd1001, 1'b1, 8'h81, 16'd49, 16'd99));
    in_ch.valid <= 1'b0;
    wait_drained();
    t_now = 32'd1001;

    // random phases, one setting each
    for (int p = 0; p < N_PHASES; p++) begin
      quiet_tail = (p == N_PHASES - 1);
      load_settings(plan[p]);
      repeat (POLLS_PER_PHASE) send_poll(random_poll());
      in_ch.valid <= 1'b0;
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* touch_report_poller_unit.f */
sv/tpr_pkg.sv
sv/tpr_if.sv
sv/tpr_cfg.sv
sv/tpr_eval.sv
sv/touch_report_poller_unit.sv
tb/sv/tpr_poll_checker.sv
tb/sv/tb_top.sv
